>>> src/lspg_pkg.sv
// lspg_pkg: shared widths, codes and pipeline payload types for the led strip pixel generator
// no dependencies; used by every module in src

package lspg_pkg;

   localparam int IDX_W      = 10;
   localparam int PHASE_W    = 11;
   localparam int CNT_W      = 11;
   localparam int COL_W      = 8;
   localparam int MODE_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int HUE_W      = 9;
   localparam int DVD_W      = 19;
   localparam int NUM_W      = 22;
   localparam int PROD_W     = 16;
   localparam int COLOR_STAGES = 4;

   localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SOLID   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CHASE   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_THEATER = 3'd4;
   localparam logic [MODE_W-1:0] MODE_PULSE   = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VALUE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = 3'd4;

   localparam logic [HUE_W-1:0] HUE_WRAP = 9'd360;

   typedef struct packed {
      logic [MODE_W-1:0]     mode;
      logic [CNT_W-1:0]      cnt;
      logic [PROD_W-1:0]     cprod;
      logic [NUM_W-1:0]      cn;
      logic [NUM_W-1:0]      mn;
      logic [CSR_DATA_W-1:0] base;
   } cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [HUE_W-1:0] phmod;
      logic             even;
      logic             third;
      logic [COL_W-1:0] level;
   } item_type;

   typedef struct packed {
      item_type         item;
      logic [DVD_W-1:0] dvd;
      logic [CNT_W-1:0] rem;
      logic [HUE_W-1:0] qm;
   } div_type;

   typedef struct packed {
      logic [COL_W-1:0] r;
      logic [COL_W-1:0] g;
      logic [COL_W-1:0] b;
   } rgb_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      rgb_type          rgb;
   } rsp_type;

endpackage

>>> src/lspg_cfg.sv
// lspg_cfg: control registers and the values derived from them (clamped count, hsv products)
// depends on lspg_pkg

module lspg_cfg #(
   parameter int LED_LIMIT = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [lspg_pkg::CSR_IDX_W-1:0]     wr_index,
   input  logic [lspg_pkg::CSR_DATA_W-1:0]    wr_data,
   output lspg_pkg::cfg_type                  cfg
);

   localparam int MW = lspg_pkg::MODE_W;
   localparam int CW = lspg_pkg::CNT_W;
   localparam int LW = lspg_pkg::COL_W;
   localparam int DW = lspg_pkg::CSR_DATA_W;
   localparam int PW = lspg_pkg::PROD_W;
   localparam int NW = lspg_pkg::NUM_W;
   localparam int CNT_FULL = (1 << CW) - 1;
   localparam int CNT_CAP  = (LED_LIMIT > CNT_FULL) ? CNT_FULL : LED_LIMIT;
   localparam logic [CW-1:0] CNT_CAP_V  = CW'(CNT_CAP);
   localparam logic [CW-1:0] CNT_RESET  = 11'd8;
   localparam logic [LW-1:0] SAT_RESET  = 8'd255;
   localparam logic [LW-1:0] VAL_RESET  = 8'd200;
   localparam logic [DW-1:0] BASE_RESET = 24'h00FFFF;
   localparam logic [LW-1:0] FULL_LEVEL = 8'd255;
   localparam logic [NW-1:0] SIXTY      = 22'd60;

   logic [MW-1:0] mode_ff;
   logic [CW-1:0] count_ff;
   logic [LW-1:0] sat_ff;
   logic [LW-1:0] value_ff;
   logic [DW-1:0] base_ff;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] cprod_ff, cprod_in;
   logic [PW-1:0] mprod_ff, mprod_in;
   logic [NW-1:0] cn_ff, cn_in;
   logic [NW-1:0] mn_ff, mn_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= lspg_pkg::MODE_OFF;
         count_ff <= CNT_RESET;
         sat_ff   <= SAT_RESET;
         value_ff <= VAL_RESET;
         base_ff  <= BASE_RESET;
      end else if (wr_en) begin
         case (wr_index)
            lspg_pkg::CSR_MODE:  mode_ff  <= wr_data[MW-1:0];
            lspg_pkg::CSR_COUNT: count_ff <= wr_data[CW-1:0];
            lspg_pkg::CSR_SAT:   sat_ff   <= wr_data[LW-1:0];
            lspg_pkg::CSR_VALUE: value_ff <= wr_data[LW-1:0];
            lspg_pkg::CSR_BASE:  base_ff  <= wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         cnt_in = CW'(1);
      end else if (count_ff > CNT_CAP_V) begin
         cnt_in = CNT_CAP_V;
      end else begin
         cnt_in = count_ff;
      end
      cprod_in = PW'(value_ff) * PW'(sat_ff);
      mprod_in = PW'(value_ff) * PW'(FULL_LEVEL - sat_ff);
      cn_in    = NW'(cprod_ff) * SIXTY;
      mn_in    = NW'(mprod_ff) * SIXTY;
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      cprod_ff <= cprod_in;
      mprod_ff <= mprod_in;
      cn_ff    <= cn_in;
      mn_ff    <= mn_in;
   end

   assign cfg.mode  = mode_ff;
   assign cfg.cnt   = cnt_ff;
   assign cfg.cprod = cprod_ff;
   assign cfg.cn    = cn_ff;
   assign cfg.mn    = mn_ff;
   assign cfg.base  = base_ff;

endmodule

>>> src/lspg_div_stage.sv
// lspg_div_stage: one restoring step of the index*360/count divider, keeping the quotient mod 360
// depends on lspg_pkg

module lspg_div_stage (
   input  logic                          clock,
   input  logic                          en,
   input  logic [lspg_pkg::CNT_W-1:0]    cnt,
   input  lspg_pkg::div_type             d,
   output lspg_pkg::div_type             q
);

   localparam int CW = lspg_pkg::CNT_W;
   localparam int DW = lspg_pkg::DVD_W;
   localparam int HW = lspg_pkg::HUE_W;

   lspg_pkg::div_type stage_ff, stage_in;

   logic [CW:0] trial;
   logic [CW:0] diff;
   logic        ge;
   logic [HW:0] q2;
   logic [HW:0] q2_wrap;

   always_comb begin
      trial   = {d.rem, d.dvd[DW-1]};
      diff    = trial - {1'b0, cnt};
      ge      = (trial >= {1'b0, cnt});
      q2      = {d.qm, ge};
      q2_wrap = q2 - {1'b0, lspg_pkg::HUE_WRAP};

      stage_in.item = d.item;
      stage_in.dvd  = {d.dvd[DW-2:0], 1'b0};
      stage_in.rem  = ge ? diff[CW-1:0] : trial[CW-1:0];
      stage_in.qm   = (q2 >= {1'b0, lspg_pkg::HUE_WRAP}) ? q2_wrap[HW-1:0] : q2[HW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign q = stage_ff;

endmodule

>>> src/lspg_color.sv
// lspg_color: hue wrap, six-sector hsv to rgb and pulse scaling over four register stages
// depends on lspg_pkg

module lspg_color (
   input  logic                 clock,
   input  logic                 en,
   input  lspg_pkg::cfg_type    cfg,
   input  lspg_pkg::div_type    d,
   output lspg_pkg::item_type   item,
   output lspg_pkg::rgb_type    rainbow,
   output lspg_pkg::rgb_type    pulse
);

   localparam int HW  = lspg_pkg::HUE_W;
   localparam int NW  = lspg_pkg::NUM_W;
   localparam int LW  = lspg_pkg::COL_W;
   localparam int PW  = lspg_pkg::PROD_W;
   localparam int PPW = 33;
   localparam int RPW = 45;
   localparam int DST_W = 6;

   localparam logic [HW-1:0] DEG_60  = 9'd60;
   localparam logic [HW-1:0] DEG_120 = 9'd120;
   localparam logic [HW-1:0] DEG_180 = 9'd180;
   localparam logic [HW-1:0] DEG_240 = 9'd240;
   localparam logic [HW-1:0] DEG_300 = 9'd300;
   localparam logic [DST_W-1:0] SPAN = 6'd60;

   // floor(n/255) = (n*65794)>>24 for n below 2^16
   localparam logic [16:0] PULSE_RECIP = 17'd65794;
   // floor(n/15300) = (n*4491470)>>36 for n below 2^22
   localparam logic [22:0] RB_RECIP    = 23'd4491470;

   localparam logic [1:0] SEL_ZERO = 2'd0;
   localparam logic [1:0] SEL_C    = 2'd1;
   localparam logic [1:0] SEL_X    = 2'd2;

   lspg_pkg::item_type item_c1_ff, item_c2_ff, item_c3_ff, item_c4_ff;

   // stage 1
   logic [HW-1:0] hue_ff, hue_in;
   logic [HW:0]   hue_sum;
   logic [HW:0]   hue_wrap;

   // stage 2
   logic [2:0][1:0]    sel_ff, sel_in;
   logic [NW-1:0]      xn_ff, xn_in;
   logic [2:0][PW-1:0] pprod_ff, pprod_in;
   logic [HW-1:0]      base_off;
   logic [HW-1:0]      f_hue;
   logic [DST_W-1:0]   sec_gap;
   logic [DST_W-1:0]   w_frac;

   // stage 3
   logic [2:0][NW-1:0]  num_ff, num_in;
   logic [2:0][LW-1:0]  pulse_ff, pulse_in;
   logic [2:0][NW-1:0]  kval;
   logic [2:0][PPW-1:0] pulse_prod;

   // stage 4
   logic [2:0][LW-1:0]  rb_ff, rb_in;
   logic [2:0][LW-1:0]  pulse_c4_ff;
   logic [2:0][RPW-1:0] rb_prod;

   always_comb begin
      hue_sum  = {1'b0, d.qm} + {1'b0, d.item.phmod};
      hue_wrap = hue_sum - {1'b0, lspg_pkg::HUE_WRAP};
      hue_in   = (hue_sum >= {1'b0, lspg_pkg::HUE_WRAP}) ? hue_wrap[HW-1:0] : hue_sum[HW-1:0];
   end

   always_comb begin
      if (hue_ff >= DEG_240) begin
         base_off = DEG_240;
      end else if (hue_ff >= DEG_120) begin
         base_off = DEG_120;
      end else begin
         base_off = '0;
      end
      f_hue = hue_ff - base_off;
      if (f_hue >= DEG_60) begin
         sec_gap = DST_W'(f_hue - DEG_60);
      end else begin
         sec_gap = DST_W'(DEG_60 - f_hue);
      end
      w_frac = SPAN - sec_gap;
      xn_in  = NW'(cfg.cprod) * NW'(w_frac);

      if (hue_ff < DEG_60) begin
         sel_in = {SEL_ZERO, SEL_X, SEL_C};
      end else if (hue_ff < DEG_120) begin
         sel_in = {SEL_ZERO, SEL_C, SEL_X};
      end else if (hue_ff < DEG_180) begin
         sel_in = {SEL_X, SEL_C, SEL_ZERO};
      end else if (hue_ff < DEG_240) begin
         sel_in = {SEL_C, SEL_X, SEL_ZERO};
      end else if (hue_ff < DEG_300) begin
         sel_in = {SEL_C, SEL_ZERO, SEL_X};
      end else begin
         sel_in = {SEL_X, SEL_ZERO, SEL_C};
      end

      for (int c = 0; c < 3; c++) begin
         pprod_in[c] = PW'(item_c1_ff.level) * PW'(cfg.base[23 - 8*c -: 8]);
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         case (sel_ff[c])
            SEL_C:   kval[c] = cfg.cn;
            SEL_X:   kval[c] = xn_ff;
            default: kval[c] = '0;
         endcase
         num_in[c]     = kval[c] + cfg.mn;
         pulse_prod[c] = PPW'(pprod_ff[c]) * PPW'(PULSE_RECIP);
         pulse_in[c]   = pulse_prod[c][31:24];
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rb_prod[c] = RPW'(num_ff[c]) * RPW'(RB_RECIP);
         rb_in[c]   = rb_prod[c][43:36];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_c1_ff  <= d.item;
         hue_ff      <= hue_in;
         item_c2_ff  <= item_c1_ff;
         sel_ff      <= sel_in;
         xn_ff       <= xn_in;
         pprod_ff    <= pprod_in;
         item_c3_ff  <= item_c2_ff;
         num_ff      <= num_in;
         pulse_ff    <= pulse_in;
         item_c4_ff  <= item_c3_ff;
         rb_ff       <= rb_in;
         pulse_c4_ff <= pulse_ff;
      end
   end

   assign item      = item_c4_ff;
   assign rainbow.r = rb_ff[0];
   assign rainbow.g = rb_ff[1];
   assign rainbow.b = rb_ff[2];
   assign pulse.r   = pulse_c4_ff[0];
   assign pulse.g   = pulse_c4_ff[1];
   assign pulse.b   = pulse_c4_ff[2];

endmodule

>>> src/led_strip_pattern_pixel_generator.sv
// led_strip_pattern_pixel_generator: top level, input stage, divider chain, colour stages, output skid
// depends on lspg_pkg, lspg_cfg, lspg_div_stage, lspg_color
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_pixel_index, req_phase
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_pixel_out, rsp_red, rsp_green, rsp_blue
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// one transaction per cycle sustained while the skid register is empty
// a result passes through the 19-step restoring divider for index*360/count plus seven other stages
// reset clears all valid bits; req_stall is high and csr_ready low while reset is high
// a stalled result is held in the output register, the next one in a skid register;
// the pipeline freezes only while the skid register is full

module led_strip_pattern_pixel_generator #(
   parameter int LED_LIMIT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lspg_pkg::IDX_W-1:0]          req_pixel_index,
   input  logic [lspg_pkg::PHASE_W-1:0]        req_phase,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lspg_pkg::IDX_W-1:0]          rsp_pixel_out,
   output logic [lspg_pkg::COL_W-1:0]          rsp_red,
   output logic [lspg_pkg::COL_W-1:0]          rsp_green,
   output logic [lspg_pkg::COL_W-1:0]          rsp_blue,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lspg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lspg_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int IW  = lspg_pkg::IDX_W;
   localparam int PHW = lspg_pkg::PHASE_W;
   localparam int HW  = lspg_pkg::HUE_W;
   localparam int DW  = lspg_pkg::DVD_W;
   localparam int LW  = lspg_pkg::COL_W;
   localparam int SW  = PHW + 1;
   localparam int NST = 2 + DW + lspg_pkg::COLOR_STAGES;

   // floor(s/3) = (s*2731)>>13 for s below 2^12
   localparam logic [11:0] MOD3_RECIP = 12'd2731;
   // floor(p/360) = (p*2913)>>20 for p below 2^11
   localparam logic [11:0] PH_RECIP   = 12'd2913;
   localparam logic [PHW-1:0] PH_STEP  = 11'd360;
   localparam logic [DW-1:0]  DEG_FULL = 19'd360;
   localparam logic [LW-1:0]  LVL_MAX  = 8'hFF;

   lspg_pkg::cfg_type  cfg;
   lspg_pkg::div_type  div_chain [DW+1];
   lspg_pkg::item_type c_item;
   lspg_pkg::rgb_type  c_rainbow;
   lspg_pkg::rgb_type  c_pulse;

   logic           en;
   logic [NST-1:0] v_ff;

   logic [IW-1:0]  in_idx_ff;
   logic [PHW-1:0] in_phase_ff;

   lspg_pkg::div_type div0_ff, div0_in;
   logic [SW-1:0]  sum_ip;
   logic [23:0]    m3_prod;
   logic [9:0]     third_q;
   logic [SW-1:0]  third_back;
   logic [22:0]    ph_prod;
   logic [2:0]     ph_q;
   logic [PHW-1:0] ph_back;
   logic [PHW-1:0] ph_rem;

   lspg_pkg::rsp_type new_rsp;
   lspg_pkg::rgb_type sel_rgb;
   logic              rsp_valid_ff, rsp_valid_in;
   lspg_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              skid_valid_ff, skid_valid_in;
   lspg_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              take;

   lspg_cfg #(
      .LED_LIMIT (LED_LIMIT)
   ) u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   assign en        = ~skid_valid_ff;
   assign req_stall = reset | ~en;
   assign csr_ready = ~reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NST-2:0], req_valid};
      end
   end

   always_comb begin
      sum_ip     = SW'(in_idx_ff) + SW'(in_phase_ff);
      m3_prod    = 24'(sum_ip) * 24'(MOD3_RECIP);
      third_q    = m3_prod[22:13];
      third_back = SW'(third_q) * SW'(3);
      ph_prod    = 23'(in_phase_ff) * 23'(PH_RECIP);
      ph_q       = ph_prod[22:20];
      ph_back    = PHW'(ph_q) * PH_STEP;
      ph_rem     = in_phase_ff - ph_back;

      div0_in.item.idx   = in_idx_ff;
      div0_in.item.phmod = ph_rem[HW-1:0];
      div0_in.item.even  = ~(in_idx_ff[0] ^ in_phase_ff[0]);
      div0_in.item.third = (sum_ip == third_back);
      div0_in.item.level = (|in_phase_ff[PHW-1:LW]) ? LVL_MAX : in_phase_ff[LW-1:0];
      div0_in.dvd        = DW'(in_idx_ff) * DEG_FULL;
      div0_in.rem        = '0;
      div0_in.qm         = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_idx_ff   <= req_pixel_index;
         in_phase_ff <= req_phase;
         div0_ff     <= div0_in;
      end
   end

   assign div_chain[0] = div0_ff;

   for (genvar k = 0; k < DW; k++) begin : g_div
      lspg_div_stage u_div (
         .clock (clock),
         .en    (en),
         .cnt   (cfg.cnt),
         .d     (div_chain[k]),
         .q     (div_chain[k+1])
      );
   end

   lspg_color u_color (
      .clock   (clock),
      .en      (en),
      .cfg     (cfg),
      .d       (div_chain[DW]),
      .item    (c_item),
      .rainbow (c_rainbow),
      .pulse   (c_pulse)
   );

   always_comb begin
      sel_rgb = '0;
      case (cfg.mode)
         lspg_pkg::MODE_SOLID: begin
            sel_rgb.r = cfg.base[23:16];
            sel_rgb.g = cfg.base[15:8];
            sel_rgb.b = cfg.base[7:0];
         end
         lspg_pkg::MODE_RAINBOW: begin
            sel_rgb = c_rainbow;
         end
         lspg_pkg::MODE_CHASE: begin
            if (c_item.even) begin
               sel_rgb.r = LVL_MAX;
            end else begin
               sel_rgb.g = LVL_MAX;
            end
         end
         lspg_pkg::MODE_THEATER: begin
            if (c_item.third) begin
               sel_rgb.r = LVL_MAX;
               sel_rgb.g = LVL_MAX;
               sel_rgb.b = LVL_MAX;
            end
         end
         lspg_pkg::MODE_PULSE: begin
            sel_rgb = c_pulse;
         end
         default: begin
            sel_rgb = '0;
         end
      endcase
      new_rsp.idx = c_item.idx;
      new_rsp.rgb = sel_rgb;
   end

   // output register plus one skid entry
   always_comb begin
      take          = ~rsp_valid_ff | ~rsp_stall;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = v_ff[NST-1];
            rsp_data_in  = new_rsp;
         end
      end else if (v_ff[NST-1] && en) begin
         skid_valid_in = 1'b1;
         skid_data_in  = new_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_data_ff.idx;
   assign rsp_red       = rsp_data_ff.rgb.r;
   assign rsp_green     = rsp_data_ff.rgb.g;
   assign rsp_blue      = rsp_data_ff.rgb.b;

endmodule

>>> src/lspg_checker.sv
// lspg_port_checks: port-level assertions for the led strip pixel generator, bound to the top level
// depends on lspg_pkg and led_strip_pattern_pixel_generator

module lspg_port_checks (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [lspg_pkg::IDX_W-1:0]          rsp_pixel_out,
   input logic [lspg_pkg::COL_W-1:0]          rsp_red,
   input logic [lspg_pkg::COL_W-1:0]          rsp_green,
   input logic [lspg_pkg::COL_W-1:0]          rsp_blue,
   input logic                                csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_pixel_out) && $stable(rsp_red) &&
                                 $stable(rsp_green) && $stable(rsp_blue))
      else $error("stalled result payload changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_closed: assert property (@(posedge clock)
      reset |-> req_stall && !csr_ready)
      else $error("transaction possible during reset");

   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$isunknown(rsp_valid))
      else $error("result valid unknown after request");

endmodule

bind led_strip_pattern_pixel_generator lspg_port_checks u_lspg_port_checks (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_pixel_out (rsp_pixel_out),
   .rsp_red       (rsp_red),
   .rsp_green     (rsp_green),
   .rsp_blue      (rsp_blue),
   .csr_ready     (csr_ready)
);
